>>> hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared constants, types and tables for the quaternion to Euler block
// Holds the arctangent table, the CORDIC cell word and the register map.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned RootSteps   = 18;

  // datapath widths
  localparam int unsigned MatW = 19;   // Q.15 matrix term, signed
  localparam int unsigned CorW = 22;   // CORDIC x/y, signed, headroom for gain
  localparam int unsigned AccW = 26;   // angle accumulator, 2^-16 degree
  localparam int unsigned SumW = 38;   // root operand
  localparam int unsigned ResW = 36;   // root result working width

  localparam logic signed [15:0] AngLimit = 16'sd23040;

  // register map
  localparam logic [0:0] RegGimbalThreshold = 1'b0;
  localparam logic [14:0] GimbalThresholdRst = 15'd33;

  typedef logic signed [AccW-1:0] acc_t;

  // one CORDIC lane word
  typedef struct packed {
    logic                   zero;   // zero vector, angle forced to 0
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    acc_t                   acc;
  } cor_lane_t;

  // per item side data carried along the cell row
  typedef struct packed {
    logic              locked;
    logic signed [1:0] s_sign;   // -1, 0, +1
  } side_t;

  function automatic acc_t atan_entry(input int unsigned i);
    acc_t r;
    case (i)
      0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
      3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
      6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
      9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
      12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
      15: r = 26'sd115;     16: r = 26'sd57;      17: r = 26'sd29;
      18: r = 26'sd14;      19: r = 26'sd7;       20: r = 26'sd4;
      21: r = 26'sd2;       22: r = 26'sd1;       default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one CORDIC vectoring micro-rotation, registered
// Turns the lane word one step toward y = 0 and hands it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  wire                clk_i,
  input  qte_pkg::cor_lane_t lane_i,
  output qte_pkg::cor_lane_t lane_o
);

  qte_pkg::cor_lane_t lane_d, lane_q;
  logic signed [qte_pkg::CorW-1:0] dx, dy;

  // shifted cross terms and direction by sign of y
  always_comb begin
    dx = lane_i.y >>> Step;
    dy = lane_i.x >>> Step;
    lane_d = lane_i;
    if (!lane_i.y[qte_pkg::CorW-1]) begin
      lane_d.x   = lane_i.x + dx;
      lane_d.y   = lane_i.y - dy;
      lane_d.acc = lane_i.acc + qte_pkg::atan_entry(Step);
    end else begin
      lane_d.x   = lane_i.x - dx;
      lane_d.y   = lane_i.y + dy;
      lane_d.acc = lane_i.acc - qte_pkg::atan_entry(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

>>> hdl/qte_root_cell.sv
// ----------------------------------------------------------------------------
// qte_root_cell: one bit of the restoring integer square root, registered
// Carries remainder and partial root along the row.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_root_cell #(
  parameter int unsigned Step = 0
) (
  input  wire                               clk_i,
  input  wire        [qte_pkg::SumW-1:0]    rem_i,
  input  wire        [qte_pkg::ResW-1:0]    res_i,
  output logic       [qte_pkg::SumW-1:0]    rem_o,
  output logic       [qte_pkg::ResW-1:0]    res_o
);

  localparam logic [qte_pkg::SumW-1:0] Bit = qte_pkg::SumW'(64'd1 << (34 - 2 * Step));

  logic [qte_pkg::SumW-1:0] trial;
  logic [qte_pkg::SumW-1:0] rem_d;
  logic [qte_pkg::ResW-1:0] res_d;

  // compare and subtract for this bit
  always_comb begin
    trial = qte_pkg::SumW'(res_i) + Bit;
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      res_d = (res_i >> 1) + Bit[qte_pkg::ResW-1:0];
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    res_o <= res_d;
  end

endmodule
`default_nettype wire

>>> hdl/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2: pipelined atan2 as a row of CORDIC cells
// Quadrant fold, Steps cells (at most TableLen), then rounding to 1/128 degree.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_atan2 #(
  parameter int unsigned Steps = qte_pkg::CordicSteps
) (
  input  wire                               clk_i,
  input  wire signed [qte_pkg::CorW-1:0]    y_i,
  input  wire signed [qte_pkg::CorW-1:0]    x_i,
  output logic signed [qte_pkg::AccW-1:0]   ang_o    // 1/128 degree, unsaturated
);

  localparam int unsigned NCells = (Steps < qte_pkg::TableLen) ? Steps : qte_pkg::TableLen;

  qte_pkg::cor_lane_t fold_d, fold_q;
  qte_pkg::cor_lane_t row [NCells+1];
  logic signed [qte_pkg::AccW-1:0] rnd;

  // quadrant fold into the right half plane
  always_comb begin
    fold_d.zero = (x_i == '0) && (y_i == '0);
    fold_d.x    = x_i;
    fold_d.y    = y_i;
    fold_d.acc  = '0;
    if (x_i[qte_pkg::CorW-1]) begin
      if (!y_i[qte_pkg::CorW-1]) begin
        fold_d.x   = y_i;
        fold_d.y   = -x_i;
        fold_d.acc = qte_pkg::AccW'(90 * 65536);
      end else begin
        fold_d.x   = -y_i;
        fold_d.y   = x_i;
        fold_d.acc = -qte_pkg::AccW'(90 * 65536);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
  end

  assign row[0] = fold_q;

  // micro-rotation cells
  for (genvar g = 0; g < NCells; g++) begin : g_cell
    qte_cordic_cell #(.Step(g)) u_cell (
      .clk_i  (clk_i),
      .lane_i (row[g]),
      .lane_o (row[g+1])
    );
  end

  // round to 1/128 degree; a zero vector gives 0
  assign rnd = (row[NCells].acc + qte_pkg::AccW'(256)) >>> 9;

  always_ff @(posedge clk_i) begin
    ang_o <= row[NCells].zero ? '0 : rnd;
  end

endmodule
`default_nettype wire

>>> hdl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: quaternion to x-y-z Euler angles
// Pipeline from the accepting edge to done_o: products, matrix terms, squares,
// 18 root cells, branch select, CORDIC fold, cells, rounding, output register.
// Throughput one word per cycle: busy_o is always low, every stage is a cell.
// Results appear for one cycle under done_o; the receiver cannot stall.
// Reset clears the valid pipeline and sets gimbal_threshold to 33.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles_top #(
  parameter int unsigned CORDIC_STEPS = qte_pkg::CordicSteps
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire signed [15:0] quat_w_i,
  input  wire signed [15:0] quat_x_i,
  input  wire signed [15:0] quat_y_i,
  input  wire signed [15:0] quat_z_i,
  output logic              done_o,
  output logic signed [15:0] angle_x_o,
  output logic signed [15:0] angle_y_o,
  output logic signed [15:0] angle_z_o,
  output logic              gimbal_locked_o,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [0:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);

  localparam int unsigned NCor  = (CORDIC_STEPS < qte_pkg::TableLen) ?
                                  CORDIC_STEPS : qte_pkg::TableLen;
  localparam int unsigned CorLat = NCor + 2;
  localparam int unsigned RLat   = qte_pkg::RootSteps;
  localparam int unsigned Lat    = 3 + RLat + 1 + CorLat + 1;
  localparam int unsigned MW     = qte_pkg::MatW;
  localparam int unsigned CW     = qte_pkg::CorW;

  // configuration register (single register at byte address 0)
  logic [14:0] thr_q;
  assign pready = 1'b1;
  assign prdata = (paddr == qte_pkg::RegGimbalThreshold) ? {17'd0, thr_q} : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qte_pkg::GimbalThresholdRst;
    end else if (psel && penable && pwrite && paddr == qte_pkg::RegGimbalThreshold) begin
      thr_q <= pwdata[14:0];
    end
  end

  assign busy_o = 1'b0;

  // stage 1: pairwise products, Q2.30
  logic signed [31:0] p_xx_q, p_yy_q, p_zz_q;
  logic signed [31:0] p_xy_q, p_wz_q, p_wy_q, p_xz_q, p_yz_q, p_wx_q;
  always_ff @(posedge clk_i) begin
    p_xx_q <= quat_x_i * quat_x_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
    p_wz_q <= quat_w_i * quat_z_i;
    p_wy_q <= quat_w_i * quat_y_i;
    p_xz_q <= quat_x_i * quat_z_i;
    p_yz_q <= quat_y_i * quat_z_i;
    p_wx_q <= quat_w_i * quat_x_i;
  end

  // stage 2: matrix terms floored to Q.15
  function automatic logic signed [MW-1:0] diag(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [35:0] t;
    t = 36'sd1073741824 - 36'(2 * (36'(a) + 36'(b)));
    return MW'(t >>> 15);
  endfunction
  function automatic logic signed [MW-1:0] offd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic neg);
    logic signed [35:0] t;
    t = neg ? 36'(2 * (36'(a) - 36'(b))) : 36'(2 * (36'(a) + 36'(b)));
    return MW'(t >>> 15);
  endfunction

  logic signed [MW-1:0] m00_q, m10_q, m20_q, m11_q, m21_q, m12_q, m22_q;
  always_ff @(posedge clk_i) begin
    m00_q <= diag(p_yy_q, p_zz_q);
    m10_q <= offd(p_xy_q, p_wz_q, 1'b1);
    m20_q <= offd(p_wy_q, p_xz_q, 1'b0);
    m11_q <= diag(p_xx_q, p_zz_q);
    m21_q <= offd(p_yz_q, p_wx_q, 1'b1);
    m12_q <= offd(p_wx_q, p_yz_q, 1'b0);
    m22_q <= diag(p_xx_q, p_yy_q);
  end

  // squares for the root operand (registered after multiply)
  logic [qte_pkg::SumW-1:0] sq0_q, sq1_q;
  logic signed [MW-1:0] d2 [7];   // m00,m10,m20,m11,m21,m12,m22 registered beside the squares
  always_ff @(posedge clk_i) begin
    sq0_q <= qte_pkg::SumW'(unsigned'(36'(m00_q * m00_q)));
    sq1_q <= qte_pkg::SumW'(unsigned'(36'(m10_q * m10_q)));
    d2[0] <= m00_q; d2[1] <= m10_q; d2[2] <= m20_q; d2[3] <= m11_q;
    d2[4] <= m21_q; d2[5] <= m12_q; d2[6] <= m22_q;
  end

  // root row, with matrix terms travelling alongside
  logic [qte_pkg::SumW-1:0] rem_r [RLat+1];
  logic [qte_pkg::ResW-1:0] res_r [RLat+1];
  logic signed [MW-1:0]     mt_r  [RLat+1][7];
  assign rem_r[0] = sq0_q + sq1_q;
  assign res_r[0] = '0;
  for (genvar k = 0; k < 7; k++) begin : g_mt0
    assign mt_r[0][k] = d2[k];
  end
  for (genvar g = 0; g < RLat; g++) begin : g_root
    qte_root_cell #(.Step(g)) u_root (
      .clk_i (clk_i),
      .rem_i (rem_r[g]), .res_i (res_r[g]),
      .rem_o (rem_r[g+1]), .res_o (res_r[g+1])
    );
    always_ff @(posedge clk_i) begin
      mt_r[g+1] <= mt_r[g];
    end
  end

  // branch select and atan2 operands
  logic [17:0] c_v;
  logic signed [MW-1:0] s_v;
  logic signed [CW-1:0] py_q, px_q, ry_q, rx_q, zy_q, zx_q;
  qte_pkg::side_t side_q;
  assign c_v = res_r[RLat][17:0];
  assign s_v = -mt_r[RLat][2];
  always_ff @(posedge clk_i) begin
    py_q <= CW'(s_v);
    px_q <= CW'({1'b0, c_v});
    side_q.locked <= !(c_v > {3'd0, thr_q});
    side_q.s_sign <= (s_v == '0) ? 2'sd0 : (s_v[MW-1] ? -2'sd1 : 2'sd1);
    if (c_v > {3'd0, thr_q}) begin
      ry_q <= CW'(mt_r[RLat][4]); rx_q <= CW'(mt_r[RLat][6]);
      zy_q <= CW'(mt_r[RLat][1]); zx_q <= CW'(mt_r[RLat][0]);
    end else begin
      ry_q <= '0; rx_q <= '0;
      zy_q <= -CW'(mt_r[RLat][5]); zx_q <= CW'(mt_r[RLat][3]);
    end
  end

  // three CORDIC rows
  logic signed [qte_pkg::AccW-1:0] ax_a, ay_a, az_a;
  qte_atan2 #(.Steps(CORDIC_STEPS)) u_roll  (.clk_i(clk_i), .y_i(ry_q), .x_i(rx_q), .ang_o(ax_a));
  qte_atan2 #(.Steps(CORDIC_STEPS)) u_pitch (.clk_i(clk_i), .y_i(py_q), .x_i(px_q), .ang_o(ay_a));
  qte_atan2 #(.Steps(CORDIC_STEPS)) u_yaw   (.clk_i(clk_i), .y_i(zy_q), .x_i(zx_q), .ang_o(az_a));

  qte_pkg::side_t side_r [CorLat+1];
  assign side_r[0] = side_q;
  for (genvar g = 0; g < CorLat; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_r[g+1] <= side_r[g];
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [qte_pkg::AccW-1:0] a);
    if (a > qte_pkg::AccW'(qte_pkg::AngLimit)) return qte_pkg::AngLimit;
    if (a < -qte_pkg::AccW'(qte_pkg::AngLimit)) return -qte_pkg::AngLimit;
    return a[15:0];
  endfunction

  // output stage
  qte_pkg::side_t sd;
  assign sd = side_r[CorLat];
  always_ff @(posedge clk_i) begin
    angle_y_o <= sat(ay_a);
    gimbal_locked_o <= sd.locked;
    if (!sd.locked) begin
      angle_x_o <= sat(ax_a);
      angle_z_o <= sat(az_a);
    end else begin
      angle_x_o <= '0;
      if (sd.s_sign == 2'sd1)       angle_z_o <= sat(-az_a);
      else if (sd.s_sign == -2'sd1) angle_z_o <= sat(az_a);
      else                          angle_z_o <= '0;
    end
  end

  // valid shift line
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  assign done_o = vld_q[Lat-1];

endmodule
`default_nettype wire
